[rtl/vn3_pkg.sv]
// Package with shared constants and the corner seed function for the 3D value noise block.
package vn3_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ValW        = 32;

  // Hash constants.
  localparam logic [31:0] HashMulY = 32'd57;
  localparam logic [31:0] HashMulZ = 32'd131;
  localparam logic [31:0] HashC1   = 32'd15731;
  localparam logic [31:0] HashC2   = 32'd789221;
  localparam logic [31:0] HashC3   = 32'd1376312589;
  localparam logic [31:0] HashMask = 32'h7fffffff;
  localparam logic signed [32:0] ValOne = 33'sd1073741824;

  // Lattice corner seed before mixing.
  function automatic logic [31:0] seed_of(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [31:0] n;
    n = x + y * HashMulY + z * HashMulZ;
    seed_of = (n << 13) ^ n;
  endfunction

endpackage

[rtl/vn3_if.sv]
// Valid/ready stream interface with a generic payload.
interface vn3_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/value_noise_3d_top.sv]
// Top level of the 3D value noise block: a stalling pipeline of hash and blend stages.
// Throughput: one beat per cycle; the whole pipeline advances while the skid buffer has room or the output is ready.
// A two-entry skid buffer at the output lets input be taken while a result waits.
// Reset clears the valid bits and the skid buffer; payload registers are not reset.
module value_noise_3d_top import vn3_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  vn3_if.sink   in_i,
  vn3_if.source out_o
);
  localparam int unsigned Depth = 11;
  localparam int unsigned UW    = FracBits;

  logic              en;
  logic [Depth-1:0]  vld_q;
  logic [1:0]        cnt_q;
  logic [31:0]       sk_q [2];
  logic [31:0]       sk_d [2];

  // Space exists if the skid buffer can take what the pipe may deliver.
  assign en       = (cnt_q != 2'd2) || out_o.ready;
  assign in_i.ready = en;

  // Stage 0: cells and weight inputs.
  logic [31:0] cx_q, cy_q, cz_q;
  logic [UW-1:0] fx_q, fy_q, fz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= 32'($signed(in_i.data.pos_x) >>> FracBits);
      cy_q <= 32'($signed(in_i.data.pos_y) >>> FracBits);
      cz_q <= 32'($signed(in_i.data.pos_z) >>> FracBits);
      fx_q <= in_i.data.pos_x[UW-1:0];
      fy_q <= in_i.data.pos_y[UW-1:0];
      fz_q <= in_i.data.pos_z[UW-1:0];
    end
  end

  // Eight corner hashes.
  logic signed [32:0] cv [8];
  for (genvar k = 0; k < 8; k++) begin : g_corner
    vn3_hash u_hash (
      .clk_i, .en_i(en),
      .x_i(((k & 1) != 0) ? cx_q + 32'd1 : cx_q),
      .y_i(((k & 2) != 0) ? cy_q + 32'd1 : cy_q),
      .z_i(((k & 4) != 0) ? cz_q + 32'd1 : cz_q),
      .val_o(cv[k])
    );
  end

  // Weights: f*f, then times (3-2f); delayed to meet the blends.
  logic [UW-1:0] ff_q [3];
  logic [UW+1:0] tt_q [3];
  logic [UW-1:0] w_q  [3];
  logic [UW-1:0] wd_q [3][6];
  logic [UW-1:0] f_s [3];
  logic [2*UW+1:0] wp [3];
  assign f_s[0] = fx_q;
  assign f_s[1] = fy_q;
  assign f_s[2] = fz_q;
  for (genvar a = 0; a < 3; a++) begin : g_w
    assign wp[a] = (2*UW+2)'(ff_q[a]) * (2*UW+2)'(tt_q[a]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        ff_q[a] <= UW'(((2*UW)'(f_s[a]) * (2*UW)'(f_s[a])) >> FracBits);
        tt_q[a] <= (UW+2)'(3 * (2**UW)) - ((UW+2)'(f_s[a]) << 1);
        w_q[a]  <= UW'(wp[a] >> FracBits);
        wd_q[a][0] <= w_q[a];
        for (int i = 1; i < 6; i++) wd_q[a][i] <= wd_q[a][i-1];
      end
    end
  end

  // Blend tree: x at hash output, then y, then z.
  logic signed [32:0] xb [4];
  logic signed [32:0] yb [2];
  logic signed [32:0] zb;
  for (genvar j = 0; j < 4; j++) begin : g_x
    vn3_lerp #(.FracBits(FracBits)) u_lx (
      .clk_i, .en_i(en), .a_i(cv[2*j]), .b_i(cv[2*j+1]), .u_i(wd_q[0][1]), .y_o(xb[j]));
  end
  for (genvar j = 0; j < 2; j++) begin : g_y
    vn3_lerp #(.FracBits(FracBits)) u_ly (
      .clk_i, .en_i(en), .a_i(xb[2*j]), .b_i(xb[2*j+1]), .u_i(wd_q[1][3]), .y_o(yb[j]));
  end
  vn3_lerp #(.FracBits(FracBits)) u_lz (
    .clk_i, .en_i(en), .a_i(yb[0]), .b_i(yb[1]), .u_i(wd_q[2][5]), .y_o(zb));

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_i.valid};
    end
  end

  // Output skid buffer, entry zero is the head.
  logic push, pop;
  assign push = en && vld_q[Depth-1];
  assign pop  = out_o.valid && out_o.ready;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Next buffer contents: shift on a pop, then place a new beat behind the rest.
  always_comb begin
    sk_d = sk_q;
    if (pop) sk_d[0] = sk_q[1];
    if (push) begin
      if (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) begin
        sk_d[0] = zb[31:0];
      end else begin
        sk_d[1] = zb[31:0];
      end
    end
  end
  always_ff @(posedge clk_i) begin
    sk_q <= sk_d;
  end
  assign out_o.valid = cnt_q != 2'd0;
  assign out_o.data.noise_value = sk_q[0];

  // Checks.
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("skid buffer overflow");
  a_in_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !out_o.ready) |-> !in_i.ready)
    else $error("input taken with full buffer");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid)
    else $error("output beat dropped");
endmodule

[rtl/vn3_lerp.sv]
// Registered blend stage: a + floor(u*(b-a) >> FracBits), two register levels.
module vn3_lerp import vn3_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [32:0]         a_i,
  input  logic signed [32:0]         b_i,
  input  logic        [FracBits-1:0] u_i,
  output logic signed [32:0]         y_o
);
  logic signed [32:0]          a_q;
  logic signed [33:0]          diff_q;
  logic        [FracBits-1:0]  u_q;
  logic signed [34+FracBits:0] prod;

  // First level: difference.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_i;
      diff_q <= 34'(b_i) - 34'(a_i);
      u_q    <= u_i;
    end
  end

  // Second level: product, arithmetic shift floors.
  assign prod = $signed({1'b0, u_q}) * diff_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_o <= a_q + 33'(prod >>> FracBits);
    end
  end
endmodule

[rtl/vn3_hash.sv]
// Corner hash pipeline: seed, square, multiply, mask; four register levels.
module vn3_hash import vn3_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        x_i,
  input  logic [31:0]        y_i,
  input  logic [31:0]        z_i,
  output logic signed [32:0] val_o
);
  logic [31:0] n_q, n2, t_q, n3_q, n4_q, s_q, m_q;

  // The constant product and the full product sit in separate levels.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= seed_of(x_i, y_i, z_i);
      n3_q <= n_q;
      t_q  <= n_q * n_q;
      n4_q <= n3_q;
      s_q  <= t_q * HashC1 + HashC2;
      m_q  <= n4_q * s_q;
    end
  end

  assign n2 = (m_q + HashC3) & HashMask;
  assign val_o = ValOne - $signed({1'b0, n2});
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the 3D value noise block: random and directed points.
`timescale 1ns / 100ps

module tb_top;
  import vn3_pkg::*;

  localparam int unsigned FracW = FracBitsDef;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } point_t;

  typedef struct packed {
    logic signed [ValW-1:0] noise_value;
  } sample_t;

  // Noise scoreboard: predicts each sample and compares the results in order.
  class noise_scoreboard;
    logic signed [ValW-1:0] samples_due[$];
    int unsigned mismatches = 0;

    // Corner value in Q2.30 from the wrapping integer hash of the lattice point.
    function automatic longint corner_value(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic [31:0] m;
      logic [31:0] h;
      m = x + y * 32'd57 + z * 32'd131;
      m = (m << 13) ^ m;
      h = (m * (m * m * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      return longint'(1073741824) - longint'({32'd0, h});
    endfunction

    // Smoothstep weight f*f*(3-2f) with truncating shifts.
    function automatic longint weight_of(logic [31:0] coord);
      longint f;
      longint sq;
      f = longint'({32'd0, coord}) & ((longint'(1) << FracW) - 1);
      sq = (f * f) >> FracW;
      return (sq * ((longint'(3) << FracW) - 2 * f)) >> FracW;
    endfunction

    // Linear blend with a floor shift of the exact product.
    function automatic longint mix(longint a, longint b, longint u);
      return a + ((u * (b - a)) >>> FracW);
    endfunction

    function automatic logic signed [ValW-1:0] predict_sample(point_t p);
      logic [31:0] cx, cy, cz, dx, dy, dz;
      longint ux, uy, uz, x00, x10, x01, x11, y0, y1;
      cx = 32'($signed(p.pos_x) >>> FracW);
      cy = 32'($signed(p.pos_y) >>> FracW);
      cz = 32'($signed(p.pos_z) >>> FracW);
      dx = cx + 32'd1;
      dy = cy + 32'd1;
      dz = cz + 32'd1;
      ux = weight_of(p.pos_x);
      uy = weight_of(p.pos_y);
      uz = weight_of(p.pos_z);
      x00 = mix(corner_value(cx, cy, cz), corner_value(dx, cy, cz), ux);
      x10 = mix(corner_value(cx, dy, cz), corner_value(dx, dy, cz), ux);
      x01 = mix(corner_value(cx, cy, dz), corner_value(dx, cy, dz), ux);
      x11 = mix(corner_value(cx, dy, dz), corner_value(dx, dy, dz), ux);
      y0 = mix(x00, x10, uy);
      y1 = mix(x01, x11, uy);
      return ValW'(mix(y0, y1, uz));
    endfunction

    function void note_point(point_t p);
      samples_due.push_back(predict_sample(p));
    endfunction

    function void check_sample(sample_t s);
      logic signed [ValW-1:0] want;
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected sample beat: noise_value=%0d", s.noise_value);
        return;
      end
      want = samples_due.pop_front();
      if (s.noise_value !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("noise_value mismatch: expected %0d, got %0d", want, s.noise_value);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 66;
  int unsigned quiet_cycles = 0;
  noise_scoreboard board = new();

  vn3_if #(.payload_t(point_t)) in_if ();
  vn3_if #(.payload_t(sample_t)) out_if ();

  value_noise_3d_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Random back pressure on the result side.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Beat monitor and stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) board.note_point(in_if.data);
      if (out_if.valid && out_if.ready) board.check_sample(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Drive one point and hold it until accepted; idle cycles come first at random.
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    p.pos_x = x;
    p.pos_y = y;
    p.pos_z = z;
    in_if.valid <= 1'b1;
    in_if.data <= p;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Coordinate with a bias toward fraction and cell edges.
  function automatic logic [31:0] pick_coord();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(5))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hffff;
      2: c = $signed(c[19:0]);
      3: c[31:16] = $urandom_range(1) ? 16'h7fff : 16'hffff;
      default: ;
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.samples_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(int unsigned count);
    repeat (count) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points: origin, extremes, fraction edges and cell wrap at the top.
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_point(32'h0000_ffff, 32'h0000_8000, 32'h0000_0001);
    send_point(32'h7fff_0000, 32'h7fff_8000, 32'h7fff_ffff);
    send_point(32'hffff_0000, 32'hfffe_8000, 32'h8000_ffff);
    send_point(32'h0001_0000, 32'hffff_0001, 32'h0000_4000);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678);
    send_point(32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987);
    send_point(32'hfffe_ffff, 32'h0000_c000, 32'h8001_0000);

    // Pause until the pipeline has handed back every sample.
    wait_drained();
    send_random(550);

    send_idle_pct = 66;
    recv_idle_pct = 33;
    send_random(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(550);

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (board.mismatches == 0 && board.samples_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
